// File: hdl/sdte_pkg.sv
// Shared types, widths and month tables for the date to epoch seconds converter.
`timescale 1ns / 1ps

package sdte_pkg;

  localparam int YEAR_W  = 14;
  localparam int FIELD_W = 7;
  localparam int DOY_W   = 9;
  localparam int YOFS_W  = 15;
  localparam int QUAD_W  = 13;
  localparam int DAYS_W  = 25;
  localparam int TOD_W   = 17;
  localparam int SECS_W  = 40;

  localparam int EPOCH_YEAR    = 1970;
  localparam int LEAP_BASE     = 1969;
  localparam int DAYS_PER_YEAR = 365;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int LEAP_FEB_LEN  = 29;

  localparam logic [FIELD_W-1:0] MONTH_FEB = 7'd2;
  localparam logic [FIELD_W-1:0] MONTH_DEC = 7'd12;
  localparam logic [FIELD_W-1:0] HOUR_MAX  = 7'd23;
  localparam logic [FIELD_W-1:0] MIN_MAX   = 7'd59;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
  } date_t;

  typedef struct packed {
    logic signed [SECS_W-1:0] epoch_seconds;
    logic                     valid_res;
  } stamp_t;

  typedef struct packed {
    logic             ok;
    logic [DOY_W-1:0] doy;
  } check_t;

  // Days in each month of a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of each month of a common year.
  function automatic logic [DOY_W-1:0] days_before(input logic [3:0] m);
    logic [DOY_W-1:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/sdte_check.sv
// Field range check and day-of-year lookup for one date.
`timescale 1ns / 1ps

module sdte_check (
  input  sdte_pkg::date_t  date,
  output sdte_pkg::check_t check
);

  logic                           leap;
  logic                           month_ok;
  logic [4:0]                     limit;
  logic                           day_ok;
  logic                           time_ok;
  logic [sdte_pkg::DOY_W-1:0]     doy_base;

  assign leap     = (date.year[1:0] == 2'b00);
  assign month_ok = (date.month != '0) && (date.month <= sdte_pkg::MONTH_DEC);

  always_comb begin
    limit = '0;
    if (month_ok) begin
      limit = sdte_pkg::month_len(date.month[3:0]);
      if (date.month == sdte_pkg::MONTH_FEB && leap) begin
        limit = 5'(sdte_pkg::LEAP_FEB_LEN);
      end
    end
  end

  assign day_ok  = (date.day != '0) && (date.day <= {2'b00, limit});
  assign time_ok = (date.hour <= sdte_pkg::HOUR_MAX) && (date.minute <= sdte_pkg::MIN_MAX)
                   && (date.second <= sdte_pkg::MIN_MAX);

  assign doy_base = sdte_pkg::days_before(date.month[3:0]);

  always_comb begin
    check.ok  = month_ok && day_ok && time_ok;
    // Leap day shifts every month after February.
    check.doy = doy_base + sdte_pkg::DOY_W'(date.day)
                + sdte_pkg::DOY_W'(date.month > sdte_pkg::MONTH_FEB && leap);
  end

endmodule

// File: hdl/server_date_to_epoch_seconds_top.sv
// Top level: pipelined UTC date and time to seconds since 1970 converter.
`timescale 1ns / 1ps
//
// Usage:
//   Drive a date on date and pulse start; the item is taken on any edge
//   where start is high and busy is low. busy stays low: a new date can
//   enter on every cycle.
//   Each date gives one result on stamp, marked by done for one cycle,
//   after the transfer has passed the stages: range check and day-of-year,
//   day count and time of day, day times 86400, final add.
//   Throughput is one item per clock, set by the four-stage pipeline.
//   valid_res low means a field was out of range; epoch_seconds is then 0.
//   Every year divisible by four counts as leap; years before 1970 give
//   negative results.
//   The receiver cannot stall: results are not held, so sample done.
//   Reset clears all stage valid bits; no result appears for items that
//   were in flight.

module server_date_to_epoch_seconds_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sdte_pkg::date_t  date,
  output logic             busy,
  output logic             done,
  output sdte_pkg::stamp_t stamp
);

  sdte_pkg::check_t check;

  // stage 1
  logic                                  v1;
  logic                                  ok1;
  logic [sdte_pkg::DOY_W-1:0]            doy1;
  logic signed [sdte_pkg::YOFS_W-1:0]    yofs1;
  logic signed [sdte_pkg::QUAD_W-1:0]    quad1;
  logic [sdte_pkg::FIELD_W-1:0]          hour1;
  logic [sdte_pkg::FIELD_W-1:0]          minute1;
  logic [sdte_pkg::FIELD_W-1:0]          second1;
  // stage 2
  logic                                  v2;
  logic                                  ok2;
  logic signed [sdte_pkg::DAYS_W-1:0]    days2;
  logic [sdte_pkg::TOD_W-1:0]            tod2;
  // stage 3
  logic                                  v3;
  logic                                  ok3;
  logic signed [sdte_pkg::SECS_W-1:0]    prod3;
  logic [sdte_pkg::TOD_W-1:0]            tod3;

  logic signed [sdte_pkg::YOFS_W-1:0]    yofs_next;
  logic signed [sdte_pkg::YOFS_W-1:0]    yleap;
  logic [sdte_pkg::YOFS_W-1:0]           ymag;
  logic [sdte_pkg::QUAD_W-1:0]           qmag;
  logic signed [sdte_pkg::QUAD_W-1:0]    quad_next;
  logic signed [sdte_pkg::DAYS_W-1:0]    days_next;
  logic [sdte_pkg::TOD_W-1:0]            tod_next;
  logic signed [sdte_pkg::SECS_W-1:0]    prod_next;
  logic signed [sdte_pkg::SECS_W-1:0]    secs_next;
  logic                                  take;

  assign busy = 1'b0;
  assign take = start && !busy;

  sdte_check u_check (
    .date  (date),
    .check (check)
  );

  // Year offsets; the leap count divides toward zero.
  always_comb begin
    yofs_next = $signed({1'b0, date.year}) - sdte_pkg::YOFS_W'(sdte_pkg::EPOCH_YEAR);
    yleap     = $signed({1'b0, date.year}) - sdte_pkg::YOFS_W'(sdte_pkg::LEAP_BASE);
    ymag      = yleap[sdte_pkg::YOFS_W-1] ? sdte_pkg::YOFS_W'(-yleap)
                                          : sdte_pkg::YOFS_W'(yleap);
    qmag      = ymag[sdte_pkg::YOFS_W-1:2];
    quad_next = yleap[sdte_pkg::YOFS_W-1] ? -$signed(qmag) : $signed(qmag);
  end

  always_comb begin
    days_next = sdte_pkg::DAYS_W'(yofs1) * sdte_pkg::DAYS_W'(sdte_pkg::DAYS_PER_YEAR)
                + sdte_pkg::DAYS_W'(quad1)
                + sdte_pkg::DAYS_W'($signed({1'b0, doy1}))
                - sdte_pkg::DAYS_W'(1);
    tod_next  = sdte_pkg::TOD_W'(hour1) * sdte_pkg::TOD_W'(sdte_pkg::SECS_PER_HOUR)
                + sdte_pkg::TOD_W'(minute1) * sdte_pkg::TOD_W'(sdte_pkg::SECS_PER_MIN)
                + sdte_pkg::TOD_W'(second1);
    prod_next = sdte_pkg::SECS_W'(days2) * sdte_pkg::SECS_W'(sdte_pkg::SECS_PER_DAY);
    secs_next = prod3 + sdte_pkg::SECS_W'($signed({1'b0, tod3}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= take;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ok1     <= check.ok;
    doy1    <= check.doy;
    yofs1   <= yofs_next;
    quad1   <= quad_next;
    hour1   <= date.hour;
    minute1 <= date.minute;
    second1 <= date.second;

    ok2   <= ok1;
    days2 <= days_next;
    tod2  <= tod_next;

    ok3   <= ok2;
    prod3 <= prod_next;
    tod3  <= tod2;

    // Drop the value of an out-of-range date.
    stamp.valid_res     <= ok3;
    stamp.epoch_seconds <= ok3 ? secs_next : '0;
  end

endmodule

// File: hdl/sdte_chk.sv
// Port-level checker for the date to epoch seconds converter, with its bind.
`timescale 1ns / 1ps

module sdte_chk (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input sdte_pkg::date_t  date,
  input logic             busy,
  input logic             done,
  input sdte_pkg::stamp_t stamp
);

  // Every transfer yields a result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("missing result four cycles after transfer");

  // No result without a matching transfer.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##4 !done)
    else $error("result without transfer");

  // Invalid results carry zero seconds.
  a_zero_bad: assert property (@(posedge clk) disable iff (rst)
    (done && !stamp.valid_res) |-> (stamp.epoch_seconds == '0))
    else $error("invalid result with nonzero seconds");

  // A zero month is always flagged.
  a_bad_month: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && date.month == '0) |-> ##4 (done && !stamp.valid_res))
    else $error("zero month not flagged");

endmodule

bind server_date_to_epoch_seconds_top sdte_chk u_sdte_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .date  (date),
  .busy  (busy),
  .done  (done),
  .stamp (stamp)
);

// File: bench/tb_server_date_to_epoch_seconds_top.sv
// Testbench for the date to epoch seconds converter: directed table, then random dates.
`timescale 1ns / 1ps

module tb_server_date_to_epoch_seconds_top;

  localparam int               RANDOM_PER_PHASE = 235;
  localparam int               SETTLE_CYCLES    = 12;
  localparam int unsigned      CYCLE_LIMIT      = 200000;
  localparam sdte_pkg::stamp_t STAMP_REJECT     = '0;

  typedef struct {
    sdte_pkg::date_t  d;
    bit               typed;
    sdte_pkg::stamp_t exp;
  } dir_row_t;

  logic             clk;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  sdte_pkg::date_t  date  = '0;
  logic             busy;
  logic             done;
  sdte_pkg::stamp_t stamp;

  sdte_pkg::stamp_t pending_stamps[$];
  dir_row_t         dir_tab[$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      sender_idle_pct = 0;

  // Sender idle percentage per phase; the receiver cannot stall, so its phases fold away.
  int unsigned phase_idle_pct[3] = '{0, 87, 34};

  int unsigned common_month_days[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned days_before_month[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                         334};

  server_date_to_epoch_seconds_top i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .date  (date),
    .busy  (busy),
    .done  (done),
    .stamp (stamp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Month length for a valid month; every year divisible by four is leap.
  function automatic int unsigned month_limit(input logic [sdte_pkg::YEAR_W-1:0] yr,
                                              input logic [sdte_pkg::FIELD_W-1:0] mo);
    int unsigned lim;
    lim = common_month_days[mo];
    if (mo == sdte_pkg::MONTH_FEB && yr[1:0] == 2'b00) lim = sdte_pkg::LEAP_FEB_LEN;
    return lim;
  endfunction

  function automatic sdte_pkg::stamp_t predict_stamp(input sdte_pkg::date_t d);
    sdte_pkg::stamp_t s;
    longint yr;
    longint doy;
    longint days;
    longint secs;
    bit     ok;
    s  = STAMP_REJECT;
    yr = longint'(d.year);
    ok = 1'b1;
    if (d.month < 1 || d.month > sdte_pkg::MONTH_DEC) ok = 1'b0;
    else if (d.day < 1 || d.day > month_limit(d.year, d.month)) ok = 1'b0;
    if (d.day < 1) ok = 1'b0;
    if (d.hour > sdte_pkg::HOUR_MAX || d.minute > sdte_pkg::MIN_MAX
        || d.second > sdte_pkg::MIN_MAX) ok = 1'b0;
    if (ok) begin
      doy = longint'(days_before_month[d.month]) + longint'(d.day);
      if (d.month > sdte_pkg::MONTH_FEB && d.year[1:0] == 2'b00) doy = doy + 1;
      // Signed division truncates toward zero for years before 1969.
      days = (yr - sdte_pkg::EPOCH_YEAR) * sdte_pkg::DAYS_PER_YEAR
             + (yr - sdte_pkg::LEAP_BASE) / 4 + doy - 1;
      secs = ((days * 24 + longint'(d.hour)) * 60 + longint'(d.minute)) * 60
             + longint'(d.second);
      s.epoch_seconds = secs[sdte_pkg::SECS_W-1:0];
      s.valid_res     = 1'b1;
    end
    return s;
  endfunction

  function automatic sdte_pkg::date_t mk_date(input int y, input int mo, input int dy,
                                              input int h, input int mi, input int sc);
    sdte_pkg::date_t d;
    d.year   = y[sdte_pkg::YEAR_W-1:0];
    d.month  = mo[sdte_pkg::FIELD_W-1:0];
    d.day    = dy[sdte_pkg::FIELD_W-1:0];
    d.hour   = h[sdte_pkg::FIELD_W-1:0];
    d.minute = mi[sdte_pkg::FIELD_W-1:0];
    d.second = sc[sdte_pkg::FIELD_W-1:0];
    return d;
  endfunction

  // Mostly well-formed dates; the rest are raw noise or a single field pushed out of range.
  function automatic sdte_pkg::date_t random_date();
    sdte_pkg::date_t d;
    logic [63:0]     raw;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 30) d.year = sdte_pkg::YEAR_W'($urandom_range(1900, 2100));
    else d.year = sdte_pkg::YEAR_W'($urandom_range(0, 16383));
    d.month  = sdte_pkg::FIELD_W'($urandom_range(1, 12));
    d.day    = sdte_pkg::FIELD_W'($urandom_range(1, month_limit(d.year, d.month)));
    d.hour   = sdte_pkg::FIELD_W'($urandom_range(0, 23));
    d.minute = sdte_pkg::FIELD_W'($urandom_range(0, 59));
    d.second = sdte_pkg::FIELD_W'($urandom_range(0, 59));
    if (pick >= 80) begin
      case ($urandom_range(0, 6))
        0, 1: begin
          raw = {$urandom, $urandom};
          d = raw[$bits(sdte_pkg::date_t)-1:0];
        end
        2: d.day = sdte_pkg::FIELD_W'(month_limit(d.year, d.month) + 1);
        3: d.month = ($urandom_range(1) == 0) ? 7'd0 : 7'd13;
        4: d.hour = sdte_pkg::FIELD_W'($urandom_range(24, 127));
        5: d.minute = sdte_pkg::FIELD_W'($urandom_range(60, 127));
        default: d.second = sdte_pkg::FIELD_W'($urandom_range(60, 127));
      endcase
    end
    return d;
  endfunction

  // Hold start until busy is low at an edge, then log the expected stamp.
  task automatic send_date(input sdte_pkg::date_t d, input sdte_pkg::stamp_t exp);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    date  <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_stamps.push_back(exp);
  endtask

  always @(posedge clk) begin
    sdte_pkg::stamp_t exp;
    if (!rst && done) begin
      if (pending_stamps.size() == 0) begin
        $error("unexpected result: epoch_seconds %0d valid_res %0b",
               stamp.epoch_seconds, stamp.valid_res);
        mismatch_count++;
      end else begin
        exp = pending_stamps.pop_front();
        if (stamp.epoch_seconds !== exp.epoch_seconds) begin
          $error("epoch_seconds mismatch: expected %0d, actual %0d",
                 exp.epoch_seconds, stamp.epoch_seconds);
          mismatch_count++;
        end
        if (stamp.valid_res !== exp.valid_res) begin
          $error("valid_res mismatch: expected %0b, actual %0b", exp.valid_res, stamp.valid_res);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    dir_tab.push_back('{mk_date(1970, 1, 1, 0, 0, 0), 1'b1,
                        sdte_pkg::stamp_t'{40'sd0, 1'b1}});
    dir_tab.push_back('{mk_date(1970, 1, 1, 0, 0, 1), 1'b1,
                        sdte_pkg::stamp_t'{40'sd1, 1'b1}});
    dir_tab.push_back('{mk_date(1969, 12, 31, 23, 59, 59), 1'b1,
                        sdte_pkg::stamp_t'{-40'sd1, 1'b1}});
    dir_tab.push_back('{mk_date(0, 1, 1, 0, 0, 0), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(1, 1, 1, 0, 0, 0), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(16383, 12, 31, 23, 59, 59), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(16380, 2, 29, 23, 59, 59), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2024, 2, 29, 12, 30, 30), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2000, 2, 29, 0, 0, 0), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2100, 2, 29, 0, 0, 0), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2100, 12, 31, 0, 0, 0), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(1968, 3, 1, 0, 0, 0), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(1965, 6, 15, 7, 8, 9), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 4, 30, 23, 59, 59), 1'b0, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2023, 2, 29, 0, 0, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2024, 2, 30, 0, 0, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 4, 31, 0, 0, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 0, 10, 0, 0, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 13, 10, 0, 0, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 5, 0, 0, 0, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 5, 31, 24, 0, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 5, 31, 23, 60, 0), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(2001, 5, 31, 23, 59, 60), 1'b1, STAMP_REJECT});
    dir_tab.push_back('{mk_date(16383, 127, 127, 127, 127, 127), 1'b1, STAMP_REJECT});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_date(dir_tab[i].d, dir_tab[i].typed ? dir_tab[i].exp : predict_stamp(dir_tab[i].d));
    end

    foreach (phase_idle_pct[p]) begin
      sender_idle_pct = phase_idle_pct[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        sdte_pkg::date_t d;
        d = random_date();
        send_date(d, predict_stamp(d));
      end
    end
    start <= 1'b0;

    // Drain the pipeline, then give stray results a chance to show up.
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/sdte_pkg.sv
hdl/sdte_check.sv
hdl/server_date_to_epoch_seconds_top.sv
hdl/sdte_chk.sv
bench/tb_server_date_to_epoch_seconds_top.sv
